FILE: rtl/core/lvfcm_pkg.sv
// shared types, constants, palette tables and colour functions of the false-colour mapper
package lvfcm_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_PALETTE_DEF = 64;
    localparam int VAL_BITS        = 16;
    localparam int DEN_BITS        = VAL_BITS + 1;
    localparam int SIZE_BITS       = 7;
    localparam int QBITS           = 7;
    localparam int IDX_BITS        = 6;
    localparam int CFG_IDX_BITS    = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LEFT   = 3'd0,
        REG_RIGHT  = 3'd1,
        REG_SCHEME = 3'd2,
        REG_FINE   = 3'd3,
        REG_FWD    = 3'd4
    } cfg_reg_t;

    localparam logic [2:0] SCH_YELLOW_RED = 3'd0;
    localparam logic [2:0] SCH_BROWN      = 3'd2;
    localparam logic [2:0] SCH_GREY       = 3'd4;
    localparam logic [2:0] SCH_BLUE       = 3'd5;

    // flags and quotient bits travelling down the divider row
    typedef struct packed {
        logic             err;
        logic             zq;
        logic [QBITS:0]   q;
    } div_ctl_t;

    // colours packed as blue, green, red
    localparam logic [23:0] PAL_BLUE16 [16] = '{
        24'hFFFFFF,24'hD5F7FF,24'hAAEAFF,24'h7AE1FF,24'h4ED5FF,24'h21CCFF,24'h00B5FF,24'h0080FF,
        24'h004BFA,24'h0065E3,24'h007FC8,24'h0058AE,24'h002D95,24'h000577,24'h00003C,24'h000000};
    localparam logic [23:0] PAL_BLUE32 [32] = '{
        24'hFFFFFF,24'hEDFBFF,24'hD5F7FF,24'hC1F1FF,24'hAAEAFF,24'h94E6FF,24'h7AE1FF,24'h65DAFF,
        24'h4ED5FF,24'h3AD0FF,24'h21CCFF,24'h0FC3FF,24'h00B5FF,24'h009AFF,24'h0080FF,24'h0066FF,
        24'h004EFF,24'h004BFA,24'h0058F2,24'h0065E3,24'h0072D9,24'h007FC8,24'h006EBF,24'h0058AE,
        24'h0043A4,24'h002D95,24'h001789,24'h000577,24'h000057,24'h00003C,24'h00002B,24'h000000};
    localparam logic [23:0] PAL_BROWN16 [16] = '{
        24'hFFFFFF,24'h8FEFFF,24'h5FD7FF,24'h67BFFF,24'h00AFFF,24'h009FFF,24'h0097EF,24'h0087DF,
        24'h0077CF,24'h0067BF,24'h005FAF,24'h004F9F,24'h003F8F,24'h002F77,24'h001F57,24'h00002F};
    localparam logic [23:0] PAL_BROWN64 [64] = '{
        24'hFFFFFF,24'hE7FFFF,24'hC7FFFF,24'hAFFFFF,24'h97F7FF,24'h77EFFF,24'h5FE7FF,24'h57DFFF,
        24'h5FD7FF,24'h5FCFFF,24'h5FC7FF,24'h5FC7FF,24'h67BFFF,24'h67BFFF,24'h3FB7FF,24'h07B7FF,
        24'h00AFFF,24'h00AFFF,24'h00A7FF,24'h00A7FF,24'h00A7FF,24'h009FFF,24'h009FFF,24'h0097FF,
        24'h0097F7,24'h0097F7,24'h008FEF,24'h008FEF,24'h0087E7,24'h0087E7,24'h0087DF,24'h007FDF,
        24'h007FD7,24'h0077D7,24'h0077CF,24'h0077CF,24'h006FC7,24'h006FC7,24'h0067BF,24'h0067BF,
        24'h0067B7,24'h005FB7,24'h005FAF,24'h0057AF,24'h0057A7,24'h0057A7,24'h004F9F,24'h004F9F,
        24'h004797,24'h004797,24'h003F8F,24'h003F8F,24'h003F87,24'h00377F,24'h00377F,24'h002F77,
        24'h002F6F,24'h002767,24'h001F5F,24'h001757,24'h00174F,24'h000F47,24'h000737,24'h00002F};

    // per-channel gradient steps for forward order, already truncated, two's complement
    localparam logic [23:0] STEP_YR16 [3] = '{24'hD60000, 24'h00DC00, 24'h0000D6};
    localparam logic [23:0] STEP_YR32 [3] = '{24'hE90000, 24'h00ED00, 24'h0000E9};
    localparam logic [23:0] STEP_OR16 [3] = '{24'hDFF600, 24'hF8F000, 24'h00F3D6};
    localparam logic [23:0] STEP_OR32 [3] = '{24'hEEFB00, 24'hFCF800, 24'h00F9E9};

    function automatic logic [SIZE_BITS-1:0] pal_size(input logic [2:0] scheme,
                                                       input logic fine, input int max_pal);
        logic [SIZE_BITS-1:0] n;
        if (!fine) n = 7'd16;
        else n = (scheme == SCH_BROWN) ? 7'd64 : 7'd32;
        if (scheme == SCH_GREY) n = 7'd16;
        if (n > SIZE_BITS'(max_pal)) n = SIZE_BITS'(max_pal);
        return n;
    endfunction

    function automatic logic [23:0] fwd_step(input logic other, input logic is32,
                                             input logic [1:0] seg);
        logic [23:0] st;
        if (other) st = is32 ? STEP_OR32[seg] : STEP_OR16[seg];
        else st = is32 ? STEP_YR32[seg] : STEP_YR16[seg];
        return st;
    endfunction

    // three-segment gradient entry
    function automatic logic [23:0] grad_color(input logic other, input logic fwd,
                                               input logic is32, input logic [IDX_BITS-1:0] idx);
        logic [23:0]         m1;
        logic [23:0]         m2;
        logic [23:0]         base;
        logic [23:0]         st;
        logic [23:0]         res;
        logic [1:0]          seg;
        logic [IDX_BITS-1:0] loc;
        m1 = other ? 24'h39C0FF : 24'h00FFFF;
        m2 = other ? 24'h004EFF : 24'h0000FF;
        if (is32) begin
            if (idx < 6'd10) begin
                seg = 2'd0; loc = idx;
            end else if (idx < 6'd22) begin
                seg = 2'd1; loc = idx - 6'd10;
            end else begin
                seg = 2'd2; loc = idx - 6'd22;
            end
        end else begin
            if (idx < 6'd5) begin
                seg = 2'd0; loc = idx;
            end else if (idx < 6'd11) begin
                seg = 2'd1; loc = idx - 6'd5;
            end else begin
                seg = 2'd2; loc = idx - 6'd11;
            end
        end
        if (fwd) begin
            st = fwd_step(other, is32, seg);
            base = (seg == 2'd0) ? 24'hFFFFFF : (seg == 2'd1) ? m1 : m2;
        end else begin
            // reversed run mirrors the forward segments with negated steps
            st = fwd_step(other, is32, 2'd2 - seg);
            st = {8'd0 - st[23:16], 8'd0 - st[15:8], 8'd0 - st[7:0]};
            base = (seg == 2'd0) ? 24'h000000 : (seg == 2'd1) ? m2 : m1;
        end
        for (int k = 0; k < 3; k++) begin
            res[8*k +: 8] = base[8*k +: 8] + 8'({2'b00, loc} * st[8*k +: 8]);
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/lvfcm_prep.sv
// front stages: offset from left value, magnitudes and scaling by palette size
module lvfcm_prep
    import lvfcm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int DW          = 17,
    parameter int AW          = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic [VAL_BITS-1:0]    left_val,
    input  logic [VAL_BITS-1:0]    right_val,
    input  logic [SIZE_BITS-1:0]   size,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [AW-1:0]          out_rem,
    output logic [DEN_BITS-1:0]    out_den,
    output div_ctl_t               out_ctl
);

    logic                 v1_reg;
    logic [DW-1:0]        absd_reg;
    logic                 dneg_reg;
    logic [DEN_BITS-1:0]  absden_reg;
    logic                 rneg_reg;
    logic                 err_reg;
    logic                 v2_reg;
    logic [AW-1:0]        rem_reg;
    logic [DEN_BITS-1:0]  den_reg;
    div_ctl_t             ctl_reg;

    logic signed [DW-1:0]       diff;
    logic signed [DEN_BITS-1:0] den;
    logic                       rdy1;
    logic                       rdy2;
    div_ctl_t                   ctl_next;

    assign diff = DW'($signed(in_sample)) - DW'($signed(left_val));
    assign den  = DEN_BITS'($signed(right_val)) - DEN_BITS'($signed(left_val));

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        ctl_next     = '0;
        ctl_next.err = err_reg;
        // opposite signs give a quotient of zero or below
        ctl_next.zq  = dneg_reg != rneg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            absd_reg   <= diff[DW-1] ? DW'(-diff) : DW'(diff);
            dneg_reg   <= diff[DW-1];
            absden_reg <= den[DEN_BITS-1] ? DEN_BITS'(-den) : DEN_BITS'(den);
            rneg_reg   <= den[DEN_BITS-1];
            err_reg    <= den == '0;
        end
        if (rdy2 && v1_reg) begin
            rem_reg <= AW'(absd_reg) * AW'(size);
            den_reg <= absden_reg;
            ctl_reg <= ctl_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_ctl   = ctl_reg;

endmodule

FILE: rtl/core/lvfcm_div_cell.sv
// one restoring-division cell: resolves one quotient bit and passes the remainder on
module lvfcm_div_cell
    import lvfcm_pkg::*;
#(
    parameter int AW    = 24,
    parameter int SHIFT = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [AW-1:0]       in_rem,
    input  logic [DEN_BITS-1:0] in_den,
    input  div_ctl_t            in_ctl,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [AW-1:0]       out_rem,
    output logic [DEN_BITS-1:0] out_den,
    output div_ctl_t            out_ctl
);

    logic                v_reg;
    logic [AW-1:0]       rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    div_ctl_t            ctl_reg;

    logic                ge;
    logic [AW-1:0]       rem_next;
    div_ctl_t            ctl_next;

    assign ge       = (in_rem >> SHIFT) >= AW'(in_den);
    assign in_ready = !v_reg || out_ready;

    always_comb begin
        ctl_next          = in_ctl;
        ctl_next.q[SHIFT] = ge;
        rem_next          = in_rem;
        // the top cell only flags overflow and leaves the remainder alone
        if (SHIFT < QBITS && ge) rem_next = in_rem - (AW'(in_den) << SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg <= rem_next;
            den_reg <= in_den;
            ctl_reg <= ctl_next;
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_ctl   = ctl_reg;

endmodule

FILE: rtl/core/lvfcm_colour.sv
// clamps the quotient to a palette index and looks up its colour into the output register
module lvfcm_colour
    import lvfcm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  div_ctl_t             in_ctl,
    input  logic [2:0]           scheme,
    input  logic                 fwd,
    input  logic [SIZE_BITS-1:0] size,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_BITS-1:0]  m_palette_index,
    output logic [7:0]           m_red,
    output logic [7:0]           m_green,
    output logic [7:0]           m_blue,
    output logic                 m_range_error
);

    logic                v_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic [23:0]         col_reg;
    logic                err_reg;

    logic [IDX_BITS-1:0]  idx;
    logic [IDX_BITS-1:0]  last;
    logic [IDX_BITS-1:0]  t;
    logic [SIZE_BITS-1:0] q;
    logic [23:0]          col;

    assign in_ready = !v_reg || m_ready;
    assign last     = IDX_BITS'(size - 7'd1);
    assign q        = in_ctl.q[QBITS-1:0];

    always_comb begin
        if (in_ctl.err || in_ctl.zq) idx = '0;
        else if (in_ctl.q[QBITS] || q >= size) idx = last;
        else idx = IDX_BITS'(q);
        t = fwd ? idx : IDX_BITS'(size - 7'd1 - SIZE_BITS'(idx));
        unique case (scheme)
            SCH_BLUE:  col = (size == 7'd32) ? PAL_BLUE32[t[4:0]] : PAL_BLUE16[t[3:0]];
            SCH_GREY:  col = {3{PAL_BROWN16[t[3:0]][7:0]}};
            SCH_BROWN: col = (size == 7'd64) ? PAL_BROWN64[t] : PAL_BROWN16[t[3:0]];
            default:   col = grad_color(scheme != SCH_YELLOW_RED, fwd, size == 7'd32, idx);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            idx_reg <= idx;
            col_reg <= col;
            err_reg <= in_ctl.err;
        end
    end

    assign m_valid         = v_reg;
    assign m_palette_index = idx_reg;
    assign m_red           = col_reg[7:0];
    assign m_green         = col_reg[15:8];
    assign m_blue          = col_reg[23:16];
    assign m_range_error   = err_reg;

endmodule

FILE: rtl/core/log_value_false_color_mapper_core.sv
// top level of the false-colour mapper: config registers, front stages, divider row, colour lookup
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_sample
//  m_        out        m_valid / m_ready   m_palette_index, m_red, m_green, m_blue,
//                                           m_range_error
//  cfg_      in         cfg_wr_en           cfg_index, cfg_wr_data
//
// one sample per clock while m_ready is held high; the pipeline has two front stages, eight divider
// cells (an overflow cell and one cell per quotient bit) and the colour output register.
// every stage holds its own valid bit, so bubbles fill while the output waits.
// aresetn is synchronous and clears only valid bits and the configuration registers.
module log_value_false_color_mapper_core
    import lvfcm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_PALETTE = MAX_PALETTE_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [SAMPLE_BITS-1:0]  s_sample,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_BITS-1:0]     m_palette_index,
    output logic [7:0]              m_red,
    output logic [7:0]              m_green,
    output logic [7:0]              m_blue,
    output logic                    m_range_error,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [VAL_BITS-1:0]     cfg_wr_data
);

    localparam int DW    = ((SAMPLE_BITS > VAL_BITS) ? SAMPLE_BITS : VAL_BITS) + 1;
    localparam int AW    = DW + SIZE_BITS;
    localparam int NCELL = QBITS + 1;

    logic [VAL_BITS-1:0]  left_reg;
    logic [VAL_BITS-1:0]  right_reg;
    logic [2:0]           scheme_reg;
    logic                 fine_reg;
    logic                 fwd_reg;
    logic [SIZE_BITS-1:0] size;

    logic                valid_c [NCELL+1];
    logic                ready_c [NCELL+1];
    logic [AW-1:0]       rem_c   [NCELL+1];
    logic [DEN_BITS-1:0] den_c   [NCELL+1];
    div_ctl_t            ctl_c   [NCELL+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            right_reg  <= 16'd360;
            scheme_reg <= '0;
            fine_reg   <= 1'b0;
            fwd_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LEFT:   left_reg   <= cfg_wr_data;
                REG_RIGHT:  right_reg  <= cfg_wr_data;
                REG_SCHEME: scheme_reg <= cfg_wr_data[2:0];
                REG_FINE:   fine_reg   <= cfg_wr_data[0];
                REG_FWD:    fwd_reg    <= cfg_wr_data[0];
                default:    ;
            endcase
        end
    end

    assign size = pal_size(scheme_reg, fine_reg, MAX_PALETTE);

    lvfcm_prep #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DW          (DW),
        .AW          (AW)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sample (s_sample),
        .left_val  (left_reg),
        .right_val (right_reg),
        .size      (size),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .out_rem   (rem_c[0]),
        .out_den   (den_c[0]),
        .out_ctl   (ctl_c[0])
    );

    // cell 0 flags overflow, the rest resolve quotient bits msb first
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        lvfcm_div_cell #(
            .AW    (AW),
            .SHIFT (QBITS - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_rem    (rem_c[i]),
            .in_den    (den_c[i]),
            .in_ctl    (ctl_c[i]),
            .out_valid (valid_c[i+1]),
            .out_ready (ready_c[i+1]),
            .out_rem   (rem_c[i+1]),
            .out_den   (den_c[i+1]),
            .out_ctl   (ctl_c[i+1])
        );
    end

    lvfcm_colour u_colour (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (valid_c[NCELL]),
        .in_ready        (ready_c[NCELL]),
        .in_ctl          (ctl_c[NCELL]),
        .scheme          (scheme_reg),
        .fwd             (fwd_reg),
        .size            (size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_palette_index (m_palette_index),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_range_error   (m_range_error)
    );

    a_err_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_palette_index == '0)
        else $error("range error with nonzero index");

    a_index_in_palette: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> SIZE_BITS'(m_palette_index) < size)
        else $error("palette index beyond palette size");

    a_err_matches_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_range_error == (left_reg == right_reg))
        else $error("range error flag disagrees with configured range");

endmodule

FILE: tb/sv/tb_log_value_false_color_mapper_core.sv
// testbench of the false-colour mapper: directed and random samples against a colour predictor
module tb_log_value_false_color_mapper_core;
    import lvfcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PIPE_DEPTH     = 11;

    typedef struct packed {
        logic [5:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       err;
    } colour_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_sample = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_palette_index;
    logic [7:0]  m_red, m_green, m_blue;
    logic        m_range_error;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = REG_LEFT;
    logic [15:0] cfg_wr_data = '0;

    // predictor copy of the registers
    logic signed [15:0] cur_left;
    logic signed [15:0] cur_right;
    logic [2:0]         cur_scheme;
    logic               cur_fine;
    logic               cur_fwd;

    colour_t expected_colours[$];
    int      mismatches = 0;
    int      samples_sent = 0;
    int      colours_seen = 0;
    int      idle_cycles = 0;
    bit      no_idle = 1'b0;

    always #2 aclk = ~aclk;

    log_value_false_color_mapper_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_palette_index(m_palette_index),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue), .m_range_error(m_range_error),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    function automatic logic [7:0] seg_channel(logic [23:0] a, logic [23:0] b, int d,
                                               int i, int k);
        int s, e, st;
        s = a[8*k +: 8];
        e = b[8*k +: 8];
        st = (e - s) / d;
        return 8'(s + i * st);
    endfunction

    function automatic logic [23:0] gradient_rgb(int size, int idx);
        logic [23:0] c0, c1, c2, c3, m1, m2, a, b;
        logic [23:0] res;
        int d, i;
        if (cur_scheme == SCH_YELLOW_RED) begin
            m1 = 24'h00FFFF; m2 = 24'h0000FF;
        end else begin
            m1 = 24'h39C0FF; m2 = 24'h004EFF;
        end
        if (cur_fwd) begin
            c0 = 24'hFFFFFF; c1 = m1; c2 = m2; c3 = 24'h000000;
        end else begin
            c0 = 24'h000000; c1 = m2; c2 = m1; c3 = 24'hFFFFFF;
        end
        if (size == 32) begin
            if (idx < 10) begin
                a = c0; b = c1; d = 11; i = idx;
            end else if (idx < 22) begin
                a = c1; b = c2; d = 13; i = idx - 10;
            end else begin
                a = c2; b = c3; d = 11; i = idx - 22;
            end
        end else begin
            if (idx < 5) begin
                a = c0; b = c1; d = 6; i = idx;
            end else if (idx < 11) begin
                a = c1; b = c2; d = 7; i = idx - 5;
            end else begin
                a = c2; b = c3; d = 6; i = idx - 11;
            end
        end
        for (int k = 0; k < 3; k++) res[8*k +: 8] = seg_channel(a, b, d, i, k);
        return res;
    endfunction

    function automatic colour_t predict_colour(logic signed [15:0] smp);
        colour_t r;
        int size, t;
        longint q;
        logic [23:0] c;
        size = !cur_fine ? 16 : (cur_scheme == SCH_BROWN ? 64 : 32);
        if (cur_scheme == SCH_GREY) size = 16;
        r.err = (cur_left == cur_right);
        if (r.err) q = 0;
        else begin
            q = ((longint'(smp) - longint'(cur_left)) * size)
                / (longint'(cur_right) - longint'(cur_left));
            if (q < 0) q = 0;
            if (q > size - 1) q = size - 1;
        end
        t = cur_fwd ? int'(q) : size - 1 - int'(q);
        if (cur_scheme == SCH_BLUE) c = (size == 32) ? PAL_BLUE32[t] : PAL_BLUE16[t];
        else if (cur_scheme == SCH_GREY) c = {3{PAL_BROWN16[t][7:0]}};
        else if (cur_scheme == SCH_BROWN) c = (size == 64) ? PAL_BROWN64[t] : PAL_BROWN16[t];
        else c = gradient_rgb(size, int'(q));
        r.index = 6'(q);
        r.red = c[7:0];
        r.green = c[15:8];
        r.blue = c[23:16];
        return r;
    endfunction

    // result side: random back-pressure and comparison
    always @(posedge aclk) begin
        colour_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_palette_index, m_red, m_green, m_blue, m_range_error};
                colours_seen++;
                if (expected_colours.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected colour %h", got);
                end else begin
                    want = expected_colours.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp idx %0d rgb %h%h%h err %b, got idx %0d rgb %h%h%h err %b",
                                     want.index, want.red, want.green, want.blue, want.err,
                                     got.index, got.red, got.green, got.blue, got.err);
                    end
                end
            end
            m_ready <= no_idle || ($urandom_range(99) >= 34);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else if (s_valid || expected_colours.size() != 0) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // valid stays high between back-to-back samples and drops only when idling
    task automatic send_sample(logic [15:0] smp);
        while (!no_idle && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_colours.push_back(predict_colour(smp));
        samples_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_colours.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LEFT:   cur_left = val;
            REG_RIGHT:  cur_right = val;
            REG_SCHEME: cur_scheme = val[2:0];
            REG_FINE:   cur_fine = val[0];
            REG_FWD:    cur_fwd = val[0];
            default: ;
        endcase
    endtask

    task automatic set_mapping(logic [15:0] l, logic [15:0] r, logic [2:0] sch, logic f,
                               logic fw);
        drain();
        write_reg(REG_LEFT, l);
        write_reg(REG_RIGHT, r);
        write_reg(REG_SCHEME, {13'd0, sch});
        write_reg(REG_FINE, {15'd0, f});
        write_reg(REG_FWD, {15'd0, fw});
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sd0);
        send_sample(16'sd180);
        send_sample(16'sd400);
        send_sample(-16'sd5);
    endtask

    task automatic test_directed();
        // full span, both orders, brown and blue schemes touched at extremes
        set_mapping(16'h8000, 16'h7FFF, 3'd2, 1'b1, 1'b1);
        send_sample(16'h8000); send_sample(16'h7FFF); send_sample(16'h0000);
        set_mapping(16'h7FFF, 16'h8000, 3'd5, 1'b1, 1'b0);
        send_sample(16'h8000); send_sample(16'h7FFF); send_sample(16'hFFFF);
        // equal range
        set_mapping(16'h0064, 16'h0064, 3'd1, 1'b0, 1'b1);
        send_sample(16'h0064); send_sample(16'h5555);
        // below and above range
        set_mapping(16'd100, 16'd200, 3'd4, 1'b1, 1'b1);
        send_sample(16'd0); send_sample(16'd150); send_sample(16'd300);
        set_mapping(16'd0, 16'd32, 3'd7, 1'b1, 1'b0);
        send_sample(16'd0); send_sample(16'd10); send_sample(16'd22); send_sample(16'd31);
        set_mapping(16'd0, 16'd16, 3'd0, 1'b0, 1'b1);
        for (int i = 0; i < 16; i += 3) send_sample(16'(i));
    endtask

    task automatic test_random();
        logic [15:0] l, r, w, smp;
        int n;
        for (int ph = 0; ph < 26; ph++) begin
            l = $urandom;
            w = (ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
            r = ($urandom_range(9) == 0) ? l : ($urandom_range(1) ? l + w : l - w);
            set_mapping(l, r, 3'($urandom_range(7)), 1'($urandom), 1'($urandom));
            no_idle = (ph == 10);
            n = 75;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(4) == 0) smp = $urandom;
                else smp = (l < r) ? l + 16'($urandom_range(0, 32'(w) + 4)) - 16'd2
                                   : r + 16'($urandom_range(0, 32'(w) + 4)) - 16'd2;
                send_sample(smp);
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        cur_left = 16'sd0;
        cur_right = 16'sd360;
        cur_scheme = 3'd0;
        cur_fine = 1'b0;
        cur_fwd = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed();
        test_random();
        drain();
        $display("sent %0d samples, checked %0d colours over all schemes, grades and orders",
                 samples_sent, colours_seen);
        if (mismatches == 0 && expected_colours.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
